// ===== rtl/actuator_homing_position_ctrl_assert.svh =====
// Assertion macros used by the checker of the actuator positioner.
`ifndef ACTUATOR_HOMING_POSITION_CTRL_ASSERT_SVH
`define ACTUATOR_HOMING_POSITION_CTRL_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define AHPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define AHPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ahpc_pkg.sv =====
// Package with the word types, codes and constants of the actuator positioner.
`default_nettype none
package ahpc_pkg;

  localparam int POS_W  = 16;
  localparam int TICK_W = 16;
  localparam int FRAC_W = 8;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(500);
  localparam logic [FRAC_W-1:0] HOME_FRACTION = FRAC_W'(128);
  localparam logic [POS_W-1:0]  POS_MAX       = '1;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_PULSE = 2'd1;
  localparam logic [1:0] REQ_MOVE  = 2'd2;

  localparam logic [1:0] DRIVE_OFF  = 2'd0;
  localparam logic [1:0] DRIVE_UP   = 2'd1;
  localparam logic [1:0] DRIVE_DOWN = 2'd2;

  localparam logic [1:0] PHASE_HOME    = 2'd0;
  localparam logic [1:0] PHASE_MEASURE = 2'd1;
  localparam logic [1:0] PHASE_READY   = 2'd2;

  // Step direction in two's complement: -1, 0, +1.
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [FRAC_W-1:0] target_fraction;
  } req_t;

  typedef struct packed {
    logic [1:0]  motor_drive;
    logic [15:0] position;
    logic [15:0] span;
    logic [15:0] target_position;
    logic [1:0]  phase;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/ahpc_state.sv =====
// Positioner state registers and the next-state logic for one event.
`default_nettype none
module ahpc_state
  import ahpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire req_t              item,
  input  wire logic [TICK_W-1:0] timeout_ticks,
  output rsp_t                   result
);

  logic [1:0]        phase, phase_next;
  logic [1:0]        drive, drive_next;
  logic [POS_W-1:0]  position, position_next;
  logic [POS_W-1:0]  target, target_next;
  logic [POS_W-1:0]  span, span_next;
  logic [1:0]        step_dir, step_dir_next;
  logic [TICK_W-1:0] timeout_left, timeout_left_next;
  logic              armed, armed_next;

  logic [FRAC_W-1:0]     mv_frac;
  logic [POS_W-1:0]      mv_span;
  logic [POS_W+FRAC_W-1:0] product;
  logic [POS_W-1:0]      mv_target;
  logic [POS_W-1:0]      pos_step;

  // The end of measuring moves to half the freshly measured span, so the
  // multiplier takes the position as span in that case.
  always_comb begin
    if (item.req_type == REQ_TICK) begin
      mv_frac = HOME_FRACTION;
      mv_span = position;
    end else begin
      mv_frac = item.target_fraction;
      mv_span = span;
    end
    product   = (POS_W+FRAC_W)'(mv_frac) * (POS_W+FRAC_W)'(mv_span);
    mv_target = product[POS_W+FRAC_W-1:FRAC_W];
  end

  always_comb begin
    pos_step = position;
    case (step_dir)
      DIR_UP: begin
        if (position != POS_MAX) pos_step = position + POS_W'(1);
      end
      DIR_DOWN: begin
        if (position != '0) pos_step = position - POS_W'(1);
      end
      default: pos_step = position;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    drive_next        = drive;
    position_next     = position;
    target_next       = target;
    span_next         = span;
    step_dir_next     = step_dir;
    timeout_left_next = timeout_left;
    armed_next        = armed;
    if (go) begin
      case (item.req_type)
        REQ_TICK: begin
          if (armed) begin
            if (timeout_left <= TICK_W'(1)) begin
              timeout_left_next = '0;
              step_dir_next     = DIR_STOP;
              drive_next        = DRIVE_OFF;
              armed_next        = 1'b0;
              case (phase)
                PHASE_HOME: begin
                  position_next     = '0;
                  phase_next        = PHASE_MEASURE;
                  drive_next        = DRIVE_UP;
                  timeout_left_next = timeout_ticks;
                  armed_next        = 1'b1;
                end
                PHASE_MEASURE: begin
                  span_next  = position;
                  phase_next = PHASE_READY;
                  if (position != '0) begin
                    target_next = mv_target;
                    if (mv_target > position) begin
                      step_dir_next     = DIR_UP;
                      drive_next        = DRIVE_UP;
                      timeout_left_next = timeout_ticks;
                      armed_next        = 1'b1;
                    end else if (mv_target < position) begin
                      step_dir_next     = DIR_DOWN;
                      drive_next        = DRIVE_DOWN;
                      timeout_left_next = timeout_ticks;
                      armed_next        = 1'b1;
                    end
                  end
                end
                default: begin
                  phase_next = phase;
                end
              endcase
            end else begin
              timeout_left_next = timeout_left - TICK_W'(1);
            end
          end
        end
        REQ_PULSE: begin
          timeout_left_next = timeout_ticks;
          armed_next        = 1'b1;
          case (phase)
            PHASE_HOME: begin
              position_next = position;
            end
            PHASE_MEASURE: begin
              if (position != POS_MAX) position_next = position + POS_W'(1);
            end
            default: begin
              position_next = pos_step;
              if (pos_step == target) begin
                step_dir_next = DIR_STOP;
                drive_next    = DRIVE_OFF;
                armed_next    = 1'b0;
              end
            end
          endcase
        end
        REQ_MOVE: begin
          if (span != '0) begin
            step_dir_next = DIR_STOP;
            drive_next    = DRIVE_OFF;
            armed_next    = 1'b0;
            target_next   = mv_target;
            if (mv_target > position) begin
              step_dir_next     = DIR_UP;
              drive_next        = DRIVE_UP;
              timeout_left_next = timeout_ticks;
              armed_next        = 1'b1;
            end else if (mv_target < position) begin
              step_dir_next     = DIR_DOWN;
              drive_next        = DRIVE_DOWN;
              timeout_left_next = timeout_ticks;
              armed_next        = 1'b1;
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PHASE_HOME;
      drive        <= DRIVE_DOWN;
      position     <= '0;
      target       <= '0;
      span         <= '0;
      step_dir     <= DIR_STOP;
      timeout_left <= TIMEOUT_RESET;
      armed        <= 1'b1;
    end else begin
      phase        <= phase_next;
      drive        <= drive_next;
      position     <= position_next;
      target       <= target_next;
      span         <= span_next;
      step_dir     <= step_dir_next;
      timeout_left <= timeout_left_next;
      armed        <= armed_next;
    end
  end

  always_comb begin
    result.motor_drive     = drive_next;
    result.position        = 16'(position_next);
    result.span            = 16'(span_next);
    result.target_position = 16'(target_next);
    result.phase           = phase_next;
  end

endmodule
`default_nettype wire

// ===== rtl/actuator_homing_position_ctrl.sv =====
// A word accepted into the input register passes the state step into the result register.
// Throughput: one word per cycle; the input register holds while the result is stalled.
// The event step (one 8x16 multiply, compares and a 16-bit count) sits between
// the input register and the result register.
// Reset: homing starts, motor down, timeout_ticks back to 500, both registers empty.
// Top level of the actuator positioner: input register, state step, result register.
`default_nettype none
module actuator_homing_position_ctrl
  import ahpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire req_t              req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output rsp_t                   rsp,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [TICK_W-1:0] cfg_data
);

  logic              item_valid;
  req_t              item;
  logic              advance;
  logic              go;
  logic [TICK_W-1:0] timeout_ticks;
  rsp_t              step_rsp;

  assign advance   = !rsp_valid || !rsp_stall;
  assign go        = item_valid && advance;
  assign req_stall = item_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!req_stall) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  ahpc_state u_state (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .item          (item),
    .timeout_ticks (timeout_ticks),
    .result        (step_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp <= step_rsp;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ahpc_checker.sv =====
// Port-level checker of the actuator positioner and its bind to the top level.
`default_nettype none
`include "actuator_homing_position_ctrl_assert.svh"
module ahpc_checker
  import ahpc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  `AHPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result word changed")
  `AHPC_ASSERT_NOW(a_span_ready, rsp_valid && rsp.span != 16'd0, rsp.phase == PHASE_READY, "span set outside ready phase")
  `AHPC_ASSERT_NOW(a_home_state, rsp_valid && rsp.phase == PHASE_HOME, rsp.position == 16'd0 && rsp.span == 16'd0 && rsp.motor_drive == DRIVE_DOWN, "homing word inconsistent")
  `AHPC_ASSERT_NOW(a_measure_state, rsp_valid && rsp.phase == PHASE_MEASURE, rsp.span == 16'd0 && rsp.motor_drive == DRIVE_UP, "measuring word inconsistent")

endmodule

bind actuator_homing_position_ctrl ahpc_checker u_ahpc_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench of the actuator positioner: homing, span, moves and timeouts.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ahpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_LIMIT    = 30;
  localparam int MAX_PULSE_RUN  = 300;
  localparam int PROD_W         = POS_W + FRAC_W;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  class position_scoreboard;
    logic [TICK_W-1:0] timeout_ticks;
    logic [TICK_W-1:0] ticks_left;
    bit                timer_armed;
    logic [1:0]        phase;
    logic [1:0]        drive;
    logic [1:0]        step_dir;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  target;
    logic [POS_W-1:0]  span;
    rsp_t              expected_words[$];
    int                mismatches;
    int                words_checked;
    int                arrivals;
    int                expiries;

    function new();
      timeout_ticks = TIMEOUT_RESET;
      ticks_left    = TIMEOUT_RESET;
      timer_armed   = 1'b1;
      phase         = PHASE_HOME;
      drive         = DRIVE_DOWN;
      step_dir      = DIR_STOP;
      position      = '0;
      target        = '0;
      span          = '0;
      mismatches    = 0;
      words_checked = 0;
      arrivals      = 0;
      expiries      = 0;
    endfunction

    function void stop_motor();
      step_dir    = DIR_STOP;
      drive       = DRIVE_OFF;
      timer_armed = 1'b0;
    endfunction

    function void rearm_timer();
      ticks_left  = timeout_ticks;
      timer_armed = 1'b1;
    endfunction

    function void begin_move(logic [FRAC_W-1:0] frac);
      logic [PROD_W-1:0] prod;
      if (span == '0) return;
      stop_motor();
      prod   = PROD_W'(frac) * PROD_W'(span);
      target = prod[PROD_W-1:FRAC_W];
      if (target > position) begin
        step_dir = DIR_UP;
        drive    = DRIVE_UP;
        rearm_timer();
      end else if (target < position) begin
        step_dir = DIR_DOWN;
        drive    = DRIVE_DOWN;
        rearm_timer();
      end
    endfunction

    function void timer_ran_out();
      case (phase)
        PHASE_HOME: begin
          stop_motor();
          position = '0;
          phase    = PHASE_MEASURE;
          rearm_timer();
          drive    = DRIVE_UP;
        end
        PHASE_MEASURE: begin
          // The measured span takes effect at once for the move to mid travel.
          stop_motor();
          span  = position;
          phase = PHASE_READY;
          begin_move(HOME_FRACTION);
        end
        default: begin
          if (drive != DRIVE_OFF) expiries++;
          stop_motor();
        end
      endcase
    endfunction

    function void tick_timer();
      if (!timer_armed) return;
      if (ticks_left <= 1) begin
        ticks_left  = '0;
        timer_armed = 1'b0;
        timer_ran_out();
      end else begin
        ticks_left--;
      end
    endfunction

    function void count_pulse();
      if (phase == PHASE_HOME) begin
        rearm_timer();
      end else if (phase == PHASE_MEASURE) begin
        rearm_timer();
        if (position != POS_MAX) position++;
      end else begin
        if (step_dir == DIR_UP) begin
          if (position != POS_MAX) position++;
        end else if (step_dir == DIR_DOWN) begin
          if (position != '0) position--;
        end
        rearm_timer();
        if (position == target) begin
          if (drive != DRIVE_OFF) arrivals++;
          stop_motor();
        end
      end
    endfunction

    function void note_event(req_t w);
      rsp_t next_word;
      case (w.req_type)
        REQ_TICK:  tick_timer();
        REQ_PULSE: count_pulse();
        REQ_MOVE:  begin_move(w.target_fraction);
        default:   ;
      endcase
      next_word.motor_drive     = drive;
      next_word.position        = position;
      next_word.span            = span;
      next_word.target_position = target;
      next_word.phase           = phase;
      expected_words.push_back(next_word);
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function string field_msg(string name, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
      return $sformatf("word %0d: %s is %0d, expected %0d", words_checked, name, got, want);
    endfunction

    task check_word(input rsp_t got);
      rsp_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", words_checked));
        return;
      end
      want = expected_words.pop_front();
      if (got.motor_drive !== want.motor_drive)
        report_mismatch(field_msg("motor_drive", POS_W'(got.motor_drive),
                                  POS_W'(want.motor_drive)));
      if (got.position !== want.position)
        report_mismatch(field_msg("position", got.position, want.position));
      if (got.span !== want.span)
        report_mismatch(field_msg("span", got.span, want.span));
      if (got.target_position !== want.target_position)
        report_mismatch(field_msg("target_position", got.target_position,
                                  want.target_position));
      if (got.phase !== want.phase)
        report_mismatch(field_msg("phase", POS_W'(got.phase), POS_W'(want.phase)));
    endtask
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  req_t              req       = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TICK_W-1:0] cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int words_sent     = 0;
  int settings_used  = 0;
  int idle_cycles    = 0;

  position_scoreboard sb;

  actuator_homing_position_ctrl dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result checking and the watchdog; input words are noted by the driver itself.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) sb.check_word(rsp);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without any handshake", idle_cycles);
        $display("FAIL actuator_homing_position_ctrl");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_word(input logic [1:0] kind, input logic [FRAC_W-1:0] frac);
    req_t w;
    w.req_type        = kind;
    w.target_fraction = frac;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_event(w);
    words_sent++;
  endtask

  task automatic send_run(input logic [1:0] kind, input logic [FRAC_W-1:0] frac,
                          input int count);
    int i;
    for (i = 0; i < count; i++) send_word(kind, frac);
  endtask

  task automatic write_timeout(input logic [TICK_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.timeout_ticks = value;
    settings_used++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A move, mostly to a fraction near the current position, then pulses that either reach
  // the target or stop short and, for a timeout of at most 16 ticks, let the timer run out.
  // Ticks between pulses stay below the timeout so that the move keeps going.
  task automatic move_sequence();
    int                eff;
    int                near;
    int                travel;
    int                n;
    int                gap;
    int                i;
    bit                arrive;
    logic [FRAC_W-1:0] frac;
    eff = (sb.timeout_ticks == '0) ? 1 : int'(sb.timeout_ticks);
    if (sb.span != '0 && $urandom_range(4) != 0) begin
      near = (int'(sb.position) * 256) / int'(sb.span) + int'($urandom_range(1));
      frac = (near > 255) ? 8'hFF : FRAC_W'(near);
    end else begin
      frac = FRAC_W'($urandom_range(255));
    end
    send_word(REQ_MOVE, frac);
    if (sb.drive == DRIVE_OFF) travel = 0;
    else if (sb.target > sb.position) travel = int'(sb.target) - int'(sb.position);
    else travel = int'(sb.position) - int'(sb.target);
    if (travel > MAX_PULSE_RUN) travel = MAX_PULSE_RUN;
    arrive = ($urandom_range(3) != 0);
    n = arrive ? travel : int'($urandom_range(travel));
    for (i = 0; i < n; i++) begin
      if (eff > 1 && $urandom_range(3) == 0) begin
        gap = $urandom_range(((eff > 4) ? 4 : eff) - 1);
        send_run(REQ_TICK, FRAC_W'($urandom_range(255)), gap);
      end
      send_word(REQ_PULSE, FRAC_W'($urandom_range(255)));
    end
    if (!arrive && eff <= 16) send_run(REQ_TICK, FRAC_W'($urandom_range(255)), eff);
  endtask

  task automatic run_random(input int budget);
    int start;
    int pick;
    int reps;
    int k;
    start = words_sent;
    while (words_sent - start < budget) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        move_sequence();
      end else if (pick < 9) begin
        reps = $urandom_range(1, 4);
        for (k = 0; k < reps; k++)
          send_word(2'($urandom_range(3)), FRAC_W'($urandom_range(255)));
      end else begin
        // A move followed by one to three pulses, so that what follows usually cuts it short.
        send_word(REQ_MOVE, FRAC_W'($urandom_range(255)));
        send_run(REQ_PULSE, FRAC_W'($urandom_range(255)), $urandom_range(1, 3));
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_timeout(TICK_W'(3));

    send_word(REQ_MOVE, 8'd200);
    send_word(REQ_UNUSED, 8'hAA);
    // The first pulse shortens the reset timeout to the written one.
    send_word(REQ_PULSE, 8'h00);
    send_run(REQ_TICK, 8'h00, 3);
    // A short measuring run sets the span to forty pulses.
    send_run(REQ_PULSE, 8'hFF, 40);
    send_run(REQ_TICK, 8'h00, 3);
    send_word(REQ_MOVE, 8'hFF);
    send_run(REQ_PULSE, 8'h00, 30);
    send_word(REQ_MOVE, 8'hFF);
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_PULSE, 8'h00);
    send_run(REQ_TICK, 8'h00, 3);
    send_word(REQ_MOVE, 8'h00);
    send_word(REQ_UNUSED, 8'h55);
    send_run(REQ_PULSE, 8'h00, 2);
    send_run(REQ_TICK, 8'h00, 3);
    send_word(REQ_MOVE, 8'h01);

    wait_idle();
    write_timeout(TICK_W'(1));
    run_random(225);

    wait_idle();
    send_idle_pct = 74;
    write_timeout('0);
    run_random(225);

    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct <= 74;
    write_timeout('1);
    run_random(225);

    wait_idle();
    send_idle_pct = 6;
    recv_stall_pct <= 6;
    write_timeout(TICK_W'($urandom_range(2, 8)));
    run_random(225);

    wait_idle();
    if (sb.expected_words.size() != 0)
      sb.report_mismatch($sformatf("%0d expected words never arrived", sb.expected_words.size()));
    $display("Checked %0d result words from %0d input words over %0d timeout settings.",
             sb.words_checked, words_sent, settings_used);
    $display("Homing and span measurement done; %0d moves arrived, %0d ended on a timeout.",
             sb.arrivals, sb.expiries);
    if (sb.mismatches == 0) begin
      $display("PASS actuator_homing_position_ctrl");
    end else begin
      $display("FAIL actuator_homing_position_ctrl");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ahpc_pkg.sv
rtl/ahpc_state.sv
rtl/actuator_homing_position_ctrl.sv
rtl/ahpc_checker.sv
test/tb.sv
